@@ rtl/periodic_trace_capture_buffer_macros.svh @@
// Assertion macros for the periodic trace capture buffer.
`ifndef PERIODIC_TRACE_CAPTURE_BUFFER_MACROS_SVH
`define PERIODIC_TRACE_CAPTURE_BUFFER_MACROS_SVH

`ifndef ASSERT_OFF
`define PTCB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");
`define PTCB_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition: label");
`else
`define PTCB_ASSERT(label, clk, rst_n, prop)
`define PTCB_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ rtl/ptcb_pkg.sv @@
// Types and constants of the periodic trace capture buffer.
`default_nettype none

package ptcb_pkg;

    localparam int CHANNELS     = 4;
    localparam int BUFFER_WORDS = 1024;
    localparam int PTR_W        = $clog2(BUFFER_WORDS);
    localparam int FILL_W       = $clog2(BUFFER_WORDS + 1);
    localparam int CH_IDX_W     = 2;
    localparam int DATA_W       = 32;
    localparam int SAMPLES_W    = 11;

    localparam logic [3:0] CH_MASK = 4'((1 << CHANNELS) - 1);

    // floor(x / 3) == (x * 683) >> 11 for every x below 2048
    localparam int RECIP3_SHIFT = 11;
    localparam logic [RECIP3_SHIFT-1:0] RECIP3 = 11'd683;

    localparam int PADDR_W = 3;

    typedef enum logic
    {
        REG_PERIOD = 1'b0,
        REG_ENABLE = 1'b1
    } reg_sel_t;

    typedef enum logic [2:0]
    {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_FLUSH = 3'd3,
        OP_READ  = 3'd4
    } opcode_t;

    typedef struct packed
    {
        logic [2:0]        opcode;
        logic [DATA_W-1:0] value_ch0;
        logic [DATA_W-1:0] value_ch1;
        logic [DATA_W-1:0] value_ch2;
        logic [DATA_W-1:0] value_ch3;
    } cmd_t;

    typedef struct packed
    {
        logic                 is_running;
        logic                 record_valid;
        logic [2:0]           word_count;
        logic [DATA_W-1:0]    record_word0;
        logic [DATA_W-1:0]    record_word1;
        logic [DATA_W-1:0]    record_word2;
        logic [DATA_W-1:0]    record_word3;
        logic [SAMPLES_W-1:0] stored_samples;
    } rsp_t;

endpackage

`default_nettype wire

@@ rtl/periodic_trace_capture_buffer.sv @@
// Periodic trace capture buffer: sequencer, trace store and register port.
//
// Requests arrive on cmd (cmd_valid/cmd_ready) carrying an opcode and four
// channel values; each request gives exactly one response on rsp
// (rsp_valid/rsp_ready). sample_period and channel_enable are written over
// the APB port (byte addresses 0 and 4); the user must do so only while the
// block is idle; the block does not enforce it. A tick that samples, and
// a read, step once over the four channel slots, at most one trace store
// access per cycle on a single-port 1024 x 32 memory: such a request
// passes a step state per slot, and a read then a drain state for the
// registered memory output; all others go straight to the result state.
// cmd_ready is high only while the sequencer is idle, so one request is
// worked on at a time. The response sits in an output register; a stalled
// receiver holds it, and the next request may be accepted and worked on
// meanwhile, waiting at the end only until the output register frees up.
// Reset stops tracing, clears the tick counter and empties the FIFO at once;
// the store contents are not cleared, and only pushed words are ever read.
`default_nettype none

`include "periodic_trace_capture_buffer_macros.svh"

module periodic_trace_capture_buffer
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output      logic                        cmd_ready,
    input  wire ptcb_pkg::cmd_t              cmd,
    output      logic                        rsp_valid,
    input  wire logic                        rsp_ready,
    output      ptcb_pkg::rsp_t              rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ptcb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output      logic [31:0]                 prdata,
    output      logic                        pready
);

    typedef enum logic [3:0]
    {
        ST_IDLE   = 4'b0001,
        ST_STEP   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t                              state_reg;
    logic [31:0]                         period_reg;
    logic [3:0]                          enable_reg;
    logic                                running_reg;
    logic [31:0]                         tick_count_reg;
    logic [ptcb_pkg::PTR_W-1:0]          wr_ptr_reg;
    logic [ptcb_pkg::PTR_W-1:0]          rd_ptr_reg;
    logic [ptcb_pkg::FILL_W-1:0]         fill_reg;
    ptcb_pkg::cmd_t                      cmd_reg;
    logic                                pop_mode_reg;
    logic [ptcb_pkg::CH_IDX_W-1:0]       ch_idx_reg;
    logic                                dry_reg;
    logic                                pend_reg;
    logic [1:0]                          pend_slot_reg;
    logic [2:0]                          count_reg;
    logic                                valid_reg;
    logic [3:0][ptcb_pkg::DATA_W-1:0]    words_reg;
    logic                                rsp_valid_reg;
    ptcb_pkg::rsp_t                      rsp_reg;

    logic [ptcb_pkg::DATA_W-1:0] mem [ptcb_pkg::BUFFER_WORDS];
    logic [ptcb_pkg::DATA_W-1:0] mem_rdata_reg;

    logic                              cmd_fire;
    logic                              cfg_write;
    logic [3:0]                        mask;
    logic [2:0]                        act;
    logic                              ch_en;
    logic                              mem_we;
    logic                              pop_go;
    logic                              dry_hit;
    logic [ptcb_pkg::PTR_W-1:0]        mem_addr;
    logic [ptcb_pkg::DATA_W-1:0]       mem_wdata;
    logic [ptcb_pkg::PTR_W-1:0]        wr_ptr_next;
    logic [ptcb_pkg::PTR_W-1:0]        rd_ptr_next;
    logic [32:0]                       tick_sum;
    logic [31:0]                       tick_count_next;
    logic                              room_ok;
    logic [21:0]                       div3_prod;
    logic [ptcb_pkg::SAMPLES_W-1:0]    samples;
    logic                              out_free;
    logic [ptcb_pkg::FILL_W-1:0]       ptr_gap;
    logic                              ptr_fill_ok;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign mask = enable_reg & ptcb_pkg::CH_MASK;
    assign act  = 3'($countones(mask));

    always_comb
    begin
        unique case (ptcb_pkg::reg_sel_t'(paddr[2]))
            ptcb_pkg::REG_PERIOD: prdata = period_reg;
            ptcb_pkg::REG_ENABLE: prdata = {28'd0, enable_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 32'd1;
            enable_reg <= 4'd0;
        end
        else if (cfg_write)
        begin
            unique case (ptcb_pkg::reg_sel_t'(paddr[2]))
                ptcb_pkg::REG_PERIOD: period_reg <= pwdata;
                ptcb_pkg::REG_ENABLE: enable_reg <= pwdata[3:0];
                default:              period_reg <= period_reg;
            endcase
        end
    end

    // tick counter advance, wrapping once the period is reached
    assign tick_sum        = {1'b0, tick_count_reg} + 33'd1;
    assign tick_count_next = (tick_sum >= {1'b0, period_reg}) ? 32'd0 : tick_sum[31:0];
    assign room_ok = (ptcb_pkg::FILL_W'(ptcb_pkg::BUFFER_WORDS) - fill_reg)
                     >= ptcb_pkg::FILL_W'(act);

    assign ch_en   = mask[ch_idx_reg];
    assign mem_we  = (state_reg == ST_STEP) && !pop_mode_reg && ch_en;
    assign pop_go  = (state_reg == ST_STEP) && pop_mode_reg && ch_en && !dry_reg
                     && (fill_reg != '0);
    assign dry_hit = (state_reg == ST_STEP) && pop_mode_reg && ch_en && !dry_reg
                     && (fill_reg == '0);
    assign mem_addr = pop_mode_reg ? rd_ptr_reg : wr_ptr_reg;

    assign wr_ptr_next = (wr_ptr_reg == ptcb_pkg::PTR_W'(ptcb_pkg::BUFFER_WORDS - 1))
                         ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == ptcb_pkg::PTR_W'(ptcb_pkg::BUFFER_WORDS - 1))
                         ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        case (ch_idx_reg)
            2'd0:    mem_wdata = cmd_reg.value_ch0;
            2'd1:    mem_wdata = cmd_reg.value_ch1;
            2'd2:    mem_wdata = cmd_reg.value_ch2;
            default: mem_wdata = cmd_reg.value_ch3;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else if (pop_go)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    assign div3_prod = 22'(fill_reg) * 22'(ptcb_pkg::RECIP3);

    always_comb
    begin
        case (act)
            3'd1:    samples = ptcb_pkg::SAMPLES_W'(fill_reg);
            3'd2:    samples = ptcb_pkg::SAMPLES_W'(fill_reg >> 1);
            3'd3:    samples = ptcb_pkg::SAMPLES_W'(div3_prod >> ptcb_pkg::RECIP3_SHIFT);
            3'd4:    samples = ptcb_pkg::SAMPLES_W'(fill_reg >> 2);
            default: samples = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            running_reg    <= 1'b0;
            tick_count_reg <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
            cmd_reg        <= '0;
            pop_mode_reg   <= 1'b0;
            ch_idx_reg     <= '0;
            dry_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            pend_slot_reg  <= '0;
            count_reg      <= '0;
            valid_reg      <= 1'b0;
            words_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && (state_reg != ST_RESULT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        cmd_reg    <= cmd;
                        ch_idx_reg <= '0;
                        dry_reg    <= 1'b0;
                        pend_reg   <= 1'b0;
                        count_reg  <= '0;
                        words_reg  <= '0;
                        valid_reg  <= (cmd.opcode == ptcb_pkg::OP_READ);
                        unique case (cmd.opcode)
                            ptcb_pkg::OP_TICK:
                            begin
                                pop_mode_reg <= 1'b0;
                                state_reg    <= (running_reg && (tick_count_reg == '0)
                                                 && room_ok) ? ST_STEP : ST_RESULT;
                                if (running_reg)
                                begin
                                    tick_count_reg <= tick_count_next;
                                    if ((tick_count_reg == '0) && !room_ok)
                                    begin
                                        running_reg <= 1'b0;
                                    end
                                end
                            end
                            ptcb_pkg::OP_START:
                            begin
                                if (!running_reg)
                                begin
                                    wr_ptr_reg <= '0;
                                    rd_ptr_reg <= '0;
                                    fill_reg   <= '0;
                                end
                                running_reg <= 1'b1;
                                state_reg   <= ST_RESULT;
                            end
                            ptcb_pkg::OP_STOP:
                            begin
                                running_reg <= 1'b0;
                                state_reg   <= ST_RESULT;
                            end
                            ptcb_pkg::OP_FLUSH:
                            begin
                                wr_ptr_reg <= '0;
                                rd_ptr_reg <= '0;
                                fill_reg   <= '0;
                                state_reg  <= ST_RESULT;
                            end
                            ptcb_pkg::OP_READ:
                            begin
                                pop_mode_reg <= 1'b1;
                                state_reg    <= ST_STEP;
                            end
                            default:
                            begin
                                state_reg <= ST_RESULT;
                            end
                        endcase
                    end
                end
                ST_STEP:
                begin
                    if (pend_reg)
                    begin
                        words_reg[pend_slot_reg] <= mem_rdata_reg;
                    end
                    pend_reg <= pop_go;
                    if (mem_we)
                    begin
                        wr_ptr_reg <= wr_ptr_next;
                        fill_reg   <= fill_reg + 1'b1;
                    end
                    if (pop_go)
                    begin
                        rd_ptr_reg    <= rd_ptr_next;
                        fill_reg      <= fill_reg - 1'b1;
                        pend_slot_reg <= count_reg[1:0];
                        count_reg     <= count_reg + 3'd1;
                    end
                    if (dry_hit)
                    begin
                        valid_reg <= 1'b0;
                        dry_reg   <= 1'b1;
                    end
                    if (ch_idx_reg == ptcb_pkg::CH_IDX_W'(ptcb_pkg::CHANNELS - 1))
                    begin
                        state_reg <= pop_mode_reg ? ST_DRAIN : ST_RESULT;
                    end
                    else
                    begin
                        ch_idx_reg <= ch_idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (pend_reg)
                    begin
                        words_reg[pend_slot_reg] <= mem_rdata_reg;
                    end
                    pend_reg  <= 1'b0;
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        rsp_reg.is_running     <= running_reg;
                        rsp_reg.record_valid   <= valid_reg;
                        rsp_reg.word_count     <= count_reg;
                        rsp_reg.record_word0   <= words_reg[0];
                        rsp_reg.record_word1   <= words_reg[1];
                        rsp_reg.record_word2   <= words_reg[2];
                        rsp_reg.record_word3   <= words_reg[3];
                        rsp_reg.stored_samples <= samples;
                        rsp_valid_reg          <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign ptr_gap = (wr_ptr_reg >= rd_ptr_reg)
                     ? ptcb_pkg::FILL_W'(wr_ptr_reg - rd_ptr_reg)
                     : ptcb_pkg::FILL_W'(ptcb_pkg::BUFFER_WORDS)
                       - ptcb_pkg::FILL_W'(rd_ptr_reg) + ptcb_pkg::FILL_W'(wr_ptr_reg);
    assign ptr_fill_ok = (fill_reg == ptr_gap)
                         || ((ptr_gap == '0)
                             && (fill_reg == ptcb_pkg::FILL_W'(ptcb_pkg::BUFFER_WORDS)));

    `PTCB_NEVER(a_fill_bound, clk, rst_n, fill_reg > ptcb_pkg::FILL_W'(ptcb_pkg::BUFFER_WORDS))
    `PTCB_ASSERT(a_ptr_fill, clk, rst_n, ptr_fill_ok)
    `PTCB_ASSERT(a_busy_after_accept, clk, rst_n, cmd_fire |=> !cmd_ready)
    `PTCB_NEVER(a_store_one_port, clk, rst_n, mem_we && pop_go)

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Testbench for the periodic trace capture buffer: stimulus, response tracking and checks.
module testbench;

    import ptcb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_ready;
    cmd_t                cmd       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_t                rsp;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    periodic_trace_capture_buffer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // shadow copy of the trace unit
    logic [31:0]           cfg_period = 32'd1;
    logic [3:0]            cfg_enable = 4'd0;
    logic                  trc_running = 1'b0;
    logic [31:0]           trc_tick = '0;
    logic [DATA_W-1:0]     trc_store [BUFFER_WORDS];
    int unsigned           trc_wr = 0;
    int unsigned           trc_rd = 0;
    int unsigned           trc_fill = 0;

    cmd_t                  cmd_pending_q [$];
    rsp_t                  trace_rsp_q [$];
    rsp_t                  want_rsp;
    int                    mismatch_count = 0;
    int                    cycle_count = 0;

    int                    burst_left = 1;
    int                    gap_left = 0;
    int                    ready_mode = 0;
    int                    ready_mode_left = 0;
    logic [7:0]            stall_pat = 8'h01;

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned lane_count(logic [3:0] m);
        int unsigned n;
        n = 0;
        for (int i = 0; i < 4; i++)
            n += m[i];
        return n;
    endfunction

    function automatic void trace_step(cmd_t c);
        rsp_t              r;
        logic [3:0]        m;
        int unsigned       act;
        int unsigned       n;
        logic [DATA_W-1:0] lane [4];
        logic [DATA_W-1:0] words [4];
        r = '0;
        m = cfg_enable & CH_MASK;
        act = lane_count(m);
        n = 0;
        lane[0] = c.value_ch0;
        lane[1] = c.value_ch1;
        lane[2] = c.value_ch2;
        lane[3] = c.value_ch3;
        for (int i = 0; i < 4; i++)
            words[i] = '0;
        case (c.opcode)
            OP_TICK:
            begin
                if (trc_running)
                begin
                    if (trc_tick == 0)
                    begin
                        if (BUFFER_WORDS - trc_fill < act)
                            trc_running = 1'b0;
                        else
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                if (m[i])
                                begin
                                    trc_store[trc_wr] = lane[i];
                                    trc_wr = (trc_wr + 1 >= BUFFER_WORDS) ? 0 : trc_wr + 1;
                                    trc_fill++;
                                end
                            end
                        end
                    end
                    trc_tick = trc_tick + 32'd1;
                    if (trc_tick >= cfg_period)
                        trc_tick = '0;
                end
            end
            OP_START:
            begin
                if (!trc_running)
                begin
                    trc_wr = 0;
                    trc_rd = 0;
                    trc_fill = 0;
                end
                trc_running = 1'b1;
            end
            OP_STOP:
                trc_running = 1'b0;
            OP_FLUSH:
            begin
                trc_wr = 0;
                trc_rd = 0;
                trc_fill = 0;
            end
            OP_READ:
            begin
                r.record_valid = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    if (m[i])
                    begin
                        if (trc_fill == 0)
                            r.record_valid = 1'b0;
                        else
                        begin
                            words[n] = trc_store[trc_rd];
                            trc_rd = (trc_rd + 1 >= BUFFER_WORDS) ? 0 : trc_rd + 1;
                            trc_fill--;
                            n++;
                        end
                    end
                end
            end
            default:
                ;
        endcase
        r.is_running     = trc_running;
        r.word_count     = 3'(n);
        r.record_word0   = words[0];
        r.record_word1   = words[1];
        r.record_word2   = words[2];
        r.record_word3   = words[3];
        r.stored_samples = (act == 0) ? '0 : SAMPLES_W'(trc_fill / act);
        trace_rsp_q.push_back(r);
    endfunction

    // request driver: bursts of random length, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid  <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                trace_step(cmd);
            if (!cmd_valid || cmd_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_pending_q.size() != 0)
                begin
                    cmd       <= cmd_pending_q.pop_front();
                    cmd_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // response monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready       <= 1'b0;
            ready_mode      <= 0;
            ready_mode_left <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (trace_rsp_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected response at cycle %0d: %p", cycle_count, rsp);
                end
                else
                begin
                    want_rsp = trace_rsp_q.pop_front();
                    if (rsp.is_running !== want_rsp.is_running
                        || rsp.record_valid !== want_rsp.record_valid
                        || rsp.word_count !== want_rsp.word_count
                        || rsp.record_word0 !== want_rsp.record_word0
                        || rsp.record_word1 !== want_rsp.record_word1
                        || rsp.record_word2 !== want_rsp.record_word2
                        || rsp.record_word3 !== want_rsp.record_word3
                        || rsp.stored_samples !== want_rsp.stored_samples)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("mismatch at cycle %0d", cycle_count);
                            $display("  expected run=%0d vld=%0d cnt=%0d w=%h %h %h %h smp=%0d",
                                     want_rsp.is_running, want_rsp.record_valid,
                                     want_rsp.word_count, want_rsp.record_word0,
                                     want_rsp.record_word1, want_rsp.record_word2,
                                     want_rsp.record_word3, want_rsp.stored_samples);
                            $display("  actual   run=%0d vld=%0d cnt=%0d w=%h %h %h %h smp=%0d",
                                     rsp.is_running, rsp.record_valid, rsp.word_count,
                                     rsp.record_word0, rsp.record_word1, rsp.record_word2,
                                     rsp.record_word3, rsp.stored_samples);
                        end
                    end
                end
            end
            if (ready_mode_left == 0)
            begin
                ready_mode      <= $urandom_range(0, 2);
                ready_mode_left <= $urandom_range(30, 200);
                stall_pat       <= 8'($urandom) | 8'h01;
            end
            else
            begin
                ready_mode_left <= ready_mode_left - 1;
                stall_pat       <= {stall_pat[6:0], stall_pat[7]};
            end
            case (ready_mode)
                0:       rsp_ready <= 1'b1;
                1:       rsp_ready <= 1'($urandom);
                default: rsp_ready <= stall_pat[0];
            endcase
        end
    end

    function automatic logic [31:0] rnd_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic cmd_t rnd_cmd(logic [2:0] op);
        cmd_t c;
        c.opcode    = op;
        c.value_ch0 = rnd_word();
        c.value_ch1 = rnd_word();
        c.value_ch2 = rnd_word();
        c.value_ch3 = rnd_word();
        return c;
    endfunction

    function automatic logic [2:0] rnd_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return OP_TICK;
        else if (r < 72)
            return OP_READ;
        else if (r < 80)
            return OP_START;
        else if (r < 85)
            return OP_STOP;
        else if (r < 90)
            return OP_FLUSH;
        else if (r < 95)
            return 3'($urandom_range(5, 7));
        return OP_TICK;
    endfunction

    task automatic reg_write(input reg_sel_t sel, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_PERIOD)
            cfg_period = val;
        else
            cfg_enable = val[3:0];
    endtask

    // hold until every request is out and every response is back
    task automatic drain();
        do
            @(negedge clk);
        while (cmd_pending_q.size() != 0 || cmd_valid || trace_rsp_q.size() != 0);
    endtask

    initial begin
        cmd_t        c;
        logic [31:0] period;
        logic [3:0]  en;
        int          n_ops;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: stopped, no channels
        cmd_pending_q.push_back(rnd_cmd(OP_TICK));
        cmd_pending_q.push_back(rnd_cmd(OP_READ));
        cmd_pending_q.push_back(rnd_cmd(OP_START));
        cmd_pending_q.push_back(rnd_cmd(OP_TICK));
        cmd_pending_q.push_back(rnd_cmd(3'd5));
        cmd_pending_q.push_back(rnd_cmd(3'd6));
        cmd_pending_q.push_back(rnd_cmd(3'd7));
        cmd_pending_q.push_back(rnd_cmd(OP_STOP));
        drain();

        reg_write(REG_PERIOD, 32'd0);
        reg_write(REG_ENABLE, 32'hF);
        cmd_pending_q.push_back(rnd_cmd(OP_START));
        c = rnd_cmd(OP_TICK);
        c.value_ch0 = '0;
        c.value_ch1 = '0;
        c.value_ch2 = '0;
        c.value_ch3 = '0;
        cmd_pending_q.push_back(c);
        c.value_ch0 = '1;
        c.value_ch1 = '1;
        c.value_ch2 = '1;
        c.value_ch3 = '1;
        cmd_pending_q.push_back(c);
        cmd_pending_q.push_back(rnd_cmd(OP_TICK));
        cmd_pending_q.push_back(rnd_cmd(OP_START));
        cmd_pending_q.push_back(rnd_cmd(OP_READ));
        cmd_pending_q.push_back(rnd_cmd(OP_READ));
        cmd_pending_q.push_back(rnd_cmd(OP_STOP));
        cmd_pending_q.push_back(rnd_cmd(OP_START));
        cmd_pending_q.push_back(rnd_cmd(OP_READ));
        cmd_pending_q.push_back(rnd_cmd(OP_FLUSH));
        drain();

        // partial record: push two words, read with four channels
        reg_write(REG_ENABLE, 32'h3);
        reg_write(REG_PERIOD, 32'd1);
        cmd_pending_q.push_back(rnd_cmd(OP_TICK));
        drain();
        reg_write(REG_ENABLE, 32'hF);
        cmd_pending_q.push_back(rnd_cmd(OP_READ));
        drain();

        // lower the period below the running counter
        reg_write(REG_ENABLE, 32'h1);
        reg_write(REG_PERIOD, 32'd100);
        cmd_pending_q.push_back(rnd_cmd(OP_FLUSH));
        for (int i = 0; i < 6; i++)
            cmd_pending_q.push_back(rnd_cmd(OP_TICK));
        drain();
        reg_write(REG_PERIOD, 32'd3);
        cmd_pending_q.push_back(rnd_cmd(OP_TICK));
        cmd_pending_q.push_back(rnd_cmd(OP_TICK));
        cmd_pending_q.push_back(rnd_cmd(OP_READ));
        cmd_pending_q.push_back(rnd_cmd(OP_READ));
        cmd_pending_q.push_back(rnd_cmd(OP_STOP));
        drain();

        // fill the store until tracing stops
        reg_write(REG_PERIOD, 32'd1);
        reg_write(REG_ENABLE, 32'hF);
        cmd_pending_q.push_back(rnd_cmd(OP_FLUSH));
        cmd_pending_q.push_back(rnd_cmd(OP_START));
        for (int i = 0; i < 258; i++)
            cmd_pending_q.push_back(rnd_cmd(OP_TICK));
        for (int i = 0; i < 6; i++)
            cmd_pending_q.push_back(rnd_cmd(OP_READ));
        cmd_pending_q.push_back(rnd_cmd(OP_TICK));
        cmd_pending_q.push_back(rnd_cmd(OP_START));
        cmd_pending_q.push_back(rnd_cmd(OP_READ));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       period = 32'hFFFF_FFFF;
                1:       period = 32'd0;
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       period = 32'd1;
                        1:       period = 32'd2;
                        2:       period = 32'd3;
                        default: period = $urandom_range(4, 9);
                    endcase
                end
            endcase
            if (ph == 0)
                en = 4'hF;
            else if (ph == 2)
                en = 4'h0;
            else
                en = 4'($urandom_range(0, 15));
            reg_write(REG_PERIOD, period);
            reg_write(REG_ENABLE, {28'd0, en});
            cmd_pending_q.push_back(rnd_cmd(OP_FLUSH));
            cmd_pending_q.push_back(rnd_cmd(OP_START));
            n_ops = $urandom_range(90, 120);
            for (int i = 0; i < n_ops; i++)
                cmd_pending_q.push_back(rnd_cmd(rnd_op()));
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && trace_rsp_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ptcb_pkg.sv
rtl/periodic_trace_capture_buffer.sv
test/testbench.sv
